@@ src/otss_pkg.sv @@
package otss_pkg;

   localparam logic [15:0] ENTERPRISE_BIT = 16'h8000;
   localparam logic [15:0] HEADER_MIN     = 16'd10;
   localparam logic [15:0] SPEC_BYTES     = 16'd4;
   localparam logic [15:0] INTERVAL_LEN   = 16'd4;
   localparam logic [15:0] ALGORITHM_LEN  = 16'd1;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_SHORT     = 3'd1;
   localparam logic [2:0] ST_NO_SCOPE  = 3'd2;
   localparam logic [2:0] ST_LEN_SHORT = 3'd3;
   localparam logic [2:0] ST_TRUNC     = 3'd4;

   localparam logic [1:0] CSR_INTERVAL_LEGACY  = 2'd0;
   localparam logic [1:0] CSR_INTERVAL_NEW     = 2'd1;
   localparam logic [1:0] CSR_ALGORITHM_LEGACY = 2'd2;
   localparam logic [1:0] CSR_ALGORITHM_NEW    = 2'd3;

   localparam logic [15:0] INTERVAL_LEGACY_RST  = 16'd34;
   localparam logic [15:0] INTERVAL_NEW_RST     = 16'd305;
   localparam logic [15:0] ALGORITHM_LEGACY_RST = 16'd35;
   localparam logic [15:0] ALGORITHM_NEW_RST    = 16'd304;

   typedef struct packed {
      logic [15:0] interval_id_legacy;
      logic [15:0] interval_id_new;
      logic [15:0] algorithm_id_legacy;
      logic [15:0] algorithm_id_new;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] template_id;
      logic [15:0] interval_offset;
      logic [15:0] algorithm_offset;
      logic        report_valid;
      logic        bad_sampler_length;
   } result_type;

endpackage

@@ src/otss_csr.sv @@
module otss_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_data,
   output otss_pkg::cfg_type cfg
);
   import otss_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_INTERVAL_LEGACY:  cfg_in.interval_id_legacy  = csr_data;
            CSR_INTERVAL_NEW:     cfg_in.interval_id_new     = csr_data;
            CSR_ALGORITHM_LEGACY: cfg_in.algorithm_id_legacy = csr_data;
            CSR_ALGORITHM_NEW:    cfg_in.algorithm_id_new    = csr_data;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interval_id_legacy  <= INTERVAL_LEGACY_RST;
         cfg_ff.interval_id_new     <= INTERVAL_NEW_RST;
         cfg_ff.algorithm_id_legacy <= ALGORITHM_LEGACY_RST;
         cfg_ff.algorithm_id_new    <= ALGORITHM_NEW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ src/otss_walk.sv @@
module otss_walk (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 beat,
   input  logic [15:0]          word,
   input  logic                 last,
   input  otss_pkg::cfg_type    cfg,
   output logic                 result_valid,
   output otss_pkg::result_type result
);
   import otss_pkg::*;

   typedef enum logic [3:0] {
      PH_SETID, PH_LEN, PH_TID, PH_FCNT, PH_SCNT,
      PH_FID, PH_FLEN, PH_ENT1, PH_ENT2, PH_DONE
   } phase_type;

   phase_type   phase_ff, phase_in, phase_nx;
   logic [15:0] bytes_ff, bytes_in, bytes_nx;
   logic [15:0] tid_ff, tid_in;
   logic [15:0] fields_ff, fields_in, fields_nx;
   logic [15:0] scopes_ff, scopes_in;
   logic [15:0] pend_ff, pend_in;
   logic [15:0] offset_ff, offset_in;
   logic [15:0] ivl_ff, ivl_in;
   logic [15:0] alg_ff, alg_in;
   logic [2:0]  err_ff, err_in, err_nx;
   logic        mism_ff, mism_in;
   logic        do_next;
   logic        is_ent;
   logic [15:0] bytes_ent;
   logic [2:0]  status;
   logic        ok;

   assign is_ent    = (pend_ff & ENTERPRISE_BIT) != 16'd0;
   assign bytes_ent = is_ent ? (bytes_ff - SPEC_BYTES) : bytes_ff;

   always_comb begin
      phase_nx  = phase_ff;
      bytes_nx  = bytes_ff;
      tid_in    = tid_ff;
      fields_nx = fields_ff;
      scopes_in = scopes_ff;
      pend_in   = pend_ff;
      offset_in = offset_ff;
      ivl_in    = ivl_ff;
      alg_in    = alg_ff;
      err_nx    = err_ff;
      mism_in   = mism_ff;
      do_next   = 1'b0;

      case (phase_ff)
         PH_SETID: phase_nx = PH_LEN;
         PH_LEN: begin
            if (word < HEADER_MIN) begin
               err_nx   = (err_ff == ST_OK) ? ST_SHORT : err_ff;
               phase_nx = PH_DONE;
            end else begin
               bytes_nx = word - HEADER_MIN;
               phase_nx = PH_TID;
            end
         end
         PH_TID: begin
            tid_in   = word;
            phase_nx = PH_FCNT;
         end
         PH_FCNT: begin
            fields_nx = word;
            phase_nx  = PH_SCNT;
         end
         PH_SCNT: begin
            scopes_in = word;
            if (word == 16'd0) begin
               err_nx   = (err_ff == ST_OK) ? ST_NO_SCOPE : err_ff;
               phase_nx = PH_DONE;
            end else if ({2'b00, bytes_ff} < {fields_ff, 2'b00}) begin
               err_nx   = (err_ff == ST_OK) ? ST_LEN_SHORT : err_ff;
               phase_nx = PH_DONE;
            end else begin
               if (word > fields_ff) fields_nx = word;
               do_next = 1'b1;
            end
         end
         PH_FID: begin
            pend_in  = word;
            phase_nx = PH_FLEN;
         end
         PH_FLEN: begin
            if (is_ent && (bytes_ff < SPEC_BYTES)) begin
               err_nx   = (err_ff == ST_OK) ? ST_TRUNC : err_ff;
               phase_nx = PH_DONE;
            end else begin
               bytes_nx = bytes_ent;
               if (scopes_ff != 16'd0) begin
                  scopes_in = scopes_ff - 16'd1;
               end else if ((pend_ff == cfg.interval_id_legacy) ||
                            (pend_ff == cfg.interval_id_new)) begin
                  if (word == INTERVAL_LEN) ivl_in = offset_ff;
                  else mism_in = 1'b1;
               end else if ((pend_ff == cfg.algorithm_id_legacy) ||
                            (pend_ff == cfg.algorithm_id_new)) begin
                  if (word == ALGORITHM_LEN) alg_in = offset_ff;
                  else mism_in = 1'b1;
               end
               offset_in = offset_ff + word;
               fields_nx = fields_ff - 16'd1;
               if (is_ent) phase_nx = PH_ENT1;
               else do_next = 1'b1;
            end
         end
         PH_ENT1: phase_nx = PH_ENT2;
         PH_ENT2: do_next = 1'b1;
         PH_DONE: phase_nx = PH_DONE;
         default: phase_nx = PH_DONE;
      endcase

      phase_in  = phase_nx;
      bytes_in  = bytes_nx;
      fields_in = fields_nx;
      err_in    = err_nx;
      if (do_next) begin
         if (fields_nx == 16'd0) begin
            phase_in = PH_DONE;
         end else if (bytes_nx < SPEC_BYTES) begin
            err_in   = (err_nx == ST_OK) ? ST_TRUNC : err_nx;
            phase_in = PH_DONE;
         end else begin
            bytes_in = bytes_nx - SPEC_BYTES;
            phase_in = PH_FID;
         end
      end
   end

   always_comb begin
      if (err_in != ST_OK) status = err_in;
      else if (phase_in inside {PH_SETID, PH_LEN, PH_TID, PH_FCNT, PH_SCNT}) status = ST_SHORT;
      else if (phase_in != PH_DONE) status = ST_TRUNC;
      else status = ST_OK;
   end

   assign ok                        = (status == ST_OK);
   assign result_valid              = beat && last;
   assign result.status             = status;
   assign result.template_id        = tid_in;
   assign result.interval_offset    = ok ? ivl_in : 16'd0;
   assign result.algorithm_offset   = ok ? alg_in : 16'd0;
   assign result.report_valid       = ok && (ivl_in != 16'd0);
   assign result.bad_sampler_length = mism_in;

   always_ff @(posedge clock) begin
      if (reset || (beat && last)) begin
         phase_ff  <= PH_SETID;
         bytes_ff  <= '0;
         tid_ff    <= '0;
         fields_ff <= '0;
         scopes_ff <= '0;
         pend_ff   <= '0;
         offset_ff <= '0;
         ivl_ff    <= '0;
         alg_ff    <= '0;
         err_ff    <= ST_OK;
         mism_ff   <= 1'b0;
      end else if (beat) begin
         phase_ff  <= phase_in;
         bytes_ff  <= bytes_in;
         tid_ff    <= tid_in;
         fields_ff <= fields_in;
         scopes_ff <= scopes_in;
         pend_ff   <= pend_in;
         offset_ff <= offset_in;
         ivl_ff    <= ivl_in;
         alg_ff    <= alg_in;
         err_ff    <= err_in;
         mism_ff   <= mism_in;
      end
   end

   a_err_done: assert property (@(posedge clock) disable iff (reset)
      (err_ff != ST_OK) |-> (phase_ff == PH_DONE))
      else $error("error code held outside done phase");

   a_walk_fields: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == PH_FID) || (phase_ff == PH_FLEN)) |-> (fields_ff != 16'd0))
      else $error("field walk with no fields left");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (beat && last) |=> ((phase_ff == PH_SETID) && (err_ff == ST_OK) && (offset_ff == 16'd0)))
      else $error("state not cleared after last beat");

endmodule

@@ src/otss_out.sv @@
module otss_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  otss_pkg::result_type load_data,
   output logic                 can_load,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output otss_pkg::result_type rsp_data
);
   import otss_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign can_load  = !valid_ff || rsp_ready;
   assign valid_in  = load || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= load_data;
   end

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> (valid_ff && (data_ff == $past(load_data))))
      else $error("loaded result not presented");

   a_report_ok: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && data_ff.report_valid) |->
         ((data_ff.status == ST_OK) && (data_ff.interval_offset != 16'd0)))
      else $error("report flagged without ok status");

endmodule

@@ src/ipfix_option_template_sampler_scan.sv @@
// Scans one IPFIX options template set, a 16-bit word per beat from the set id
// onwards, and returns one result on the beat flagged last: status, template id
// and the record offsets of the sampling interval and sampling algorithm fields.
// A word can be accepted on every clock; the result appears on rsp_ in the
// cycle after the last beat is accepted, from a single output register, and the
// input stalls only while that register holds a result not yet taken. The four
// element-id registers are written through csr_ (index 0 to 3) and should be
// changed only between sets.
module ipfix_option_template_sampler_scan (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_word,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_template_id,
   output logic [15:0] rsp_interval_offset,
   output logic [15:0] rsp_algorithm_offset,
   output logic        rsp_report_valid,
   output logic        rsp_bad_sampler_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import otss_pkg::*;

   cfg_type    cfg;
   result_type result;
   result_type rsp_data;
   logic       result_valid;
   logic       can_load;
   logic       beat;

   assign req_ready = can_load;
   assign beat      = req_valid && req_ready;

   otss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   otss_walk u_walk (
      .clock        (clock),
      .reset        (reset),
      .beat         (beat),
      .word         (req_word),
      .last         (req_last),
      .cfg          (cfg),
      .result_valid (result_valid),
      .result       (result)
   );

   otss_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (result_valid),
      .load_data (result),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_status             = rsp_data.status;
   assign rsp_template_id        = rsp_data.template_id;
   assign rsp_interval_offset    = rsp_data.interval_offset;
   assign rsp_algorithm_offset   = rsp_data.algorithm_offset;
   assign rsp_report_valid       = rsp_data.report_valid;
   assign rsp_bad_sampler_length = rsp_data.bad_sampler_length;

endmodule
